[rtl/lrd_pkg.sv]
// Package for the log record deframer: phase, kind and status codes,
// the transfer structs passed between stages, and the CRC-32 byte update.
// No dependencies.
package lrd_pkg;

    // Default width of the byte offset counters.
    localparam int OFFSET_BITS_DEF = 48;

    // Fixed widths of the result fields.
    localparam int SEQ_W  = 64;
    localparam int TOFF_W = 48;

    // Reflected CRC-32 polynomial and its initial value.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Parser phase within one record.
    typedef enum logic [2:0] {
        PH_SEQ  = 3'd0,
        PH_OP   = 3'd1,
        PH_KLEN = 3'd2,
        PH_VLEN = 3'd3,
        PH_KEY  = 3'd4,
        PH_VAL  = 3'd5,
        PH_CRC  = 3'd6
    } t_phase;

    // What a result transfer carries.
    typedef enum logic [1:0] {
        KIND_KEY        = 2'd0,
        KIND_VALUE      = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_STREAM_END = 2'd3
    } t_kind;

    // Record and stream status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_OPCODE = 3'd1,
        ST_CRC_ERR    = 3'd2,
        ST_SEQ_ORDER  = 3'd3,
        ST_SEQ_EXHAUST = 3'd4,
        ST_TAIL       = 3'd5
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_PUT_CODE    = 1'b0;
    localparam logic CFG_DELETE_CODE = 1'b1;

    // One input item held in the input stage.
    typedef struct packed {
        logic       eol;
        logic [7:0] data;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic               any_records;
        logic [SEQ_W-1:0]   next_sequence;
        logic [TOFF_W-1:0]  truncate_offset;
        t_status            status;
        logic               record_op;
        logic [SEQ_W-1:0]   sequence_res;
        logic [7:0]         payload_byte;
        t_kind              kind;
    } t_result;

    // Reflected CRC-32 update by one byte, one bit per step.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/log_record_deframer_crc32.sv]
// Top level of the log record deframer: stream ports, input register and
// record parser. Depends on lrd_pkg, lrd_in_stage and lrd_parser.
//
// Channel   Direction  Handshake           Contents
// s_        in         s_tvalid/s_tready   tdata: data_byte; tuser: end_of_log
// m_        out        m_tvalid/m_tready   tdata: record fields; tuser: kind
// cfg       in         i_cfg_we            i_cfg_idx selects put/delete code
//
// One byte is taken per cycle while m_ is not stalled; an input transfer passes
// through the input register, the parser and then the result register.
// Reset is synchronous and active low; it clears all parser state at once.
// A stall on m_ holds the result; one more input transfer is still taken
// into the input register before s_tready drops.
module log_record_deframer_crc32 #(
    parameter int OFFSET_BITS = lrd_pkg::OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [7:0]   i_cfg_data,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] end_of_log
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] payload_byte, [71:8] sequence_res, [72] record_op, [75:73] status,
    // [123:76] truncate_offset, [187:124] next_sequence, [188] any_records,
    // [191:189] zero
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser    // [1:0] kind
);
    import lrd_pkg::*;

    t_in_item w_in_item;
    t_in_item w_held_item;
    logic     w_held_valid;
    logic     w_take;
    t_result  w_res;

    assign w_in_item.data = s_tdata;
    assign w_in_item.eol  = s_tuser;

    // Input register.
    lrd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Parser with result register.
    lrd_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (w_held_valid),
        .i_in_item  (w_held_item),
        .o_take     (w_take),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_result   (w_res)
    );

    // Pack the result fields, highest first.
    assign m_tdata = {3'b000,
                      w_res.any_records,
                      w_res.next_sequence,
                      w_res.truncate_offset,
                      w_res.status,
                      w_res.record_op,
                      w_res.sequence_res,
                      w_res.payload_byte};
    assign m_tuser = w_res.kind;

endmodule

[rtl/lrd_in_stage.sv]
// Input register of the log record deframer: holds one accepted transfer
// until the parser consumes it. Depends on lrd_pkg.
module lrd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lrd_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output lrd_pkg::t_in_item o_item
);
    import lrd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The register can take a new transfer when empty or emptied this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/lrd_parser.sv]
// Record parser and result register of the log record deframer: field
// state, CRC check, sequence checks and error latch. Depends on lrd_pkg.
module lrd_parser #(
    parameter int OFFSET_BITS = lrd_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  lrd_pkg::t_in_item i_in_item,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output lrd_pkg::t_result  o_result
);
    import lrd_pkg::*;

    // Configuration.
    logic [7:0] r_put_code;
    logic [7:0] r_del_code;

    // Parser state.
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_fbc, n_fbc;
    logic [63:0]            r_seq, n_seq;
    logic                   r_op, n_op;
    logic [31:0]            r_klen, n_klen;
    logic [31:0]            r_vlen, n_vlen;
    logic [31:0]            r_left, n_left;
    logic [31:0]            r_crc, n_crc;
    logic [23:0]            r_stored, n_stored;
    logic [63:0]            r_prev, n_prev;
    logic                   r_have_prev, n_have_prev;
    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_BITS-1:0] r_record_start, n_record_start;
    t_status                r_err, n_err;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic        w_adv;
    logic        w_active;
    logic        w_start;
    logic [7:0]  w_b;
    logic [63:0] w_seq_base;
    logic [31:0] w_crc_base;
    logic [31:0] w_crc_next;
    logic [31:0] w_vlen_full;
    logic [31:0] w_left_dec;
    logic [31:0] w_stored_full;
    logic        w_is_put;
    logic        w_is_del;
    logic [63:0] w_rs_ext;
    logic        w_emit;
    t_result     w_res;
    t_status     w_st;

    // The item in the input register moves on when the result slot is free.
    assign w_adv    = i_in_valid && (!r_out_valid || i_ready);
    assign o_take   = w_adv;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Shared decode of the current byte.
    assign w_b           = i_in_item.data;
    assign w_active      = w_adv && !i_in_item.eol && (r_err == ST_OK);
    assign w_start       = (r_phase == PH_SEQ) && (r_fbc == 3'd0);
    assign w_seq_base    = w_start ? 64'd0 : r_seq;
    assign w_crc_base    = w_start ? CRC_INIT : r_crc;
    assign w_crc_next    = crc32_byte(w_crc_base, w_b);
    assign w_is_put      = (w_b == r_put_code);
    assign w_is_del      = (w_b == r_del_code);
    assign w_left_dec    = r_left - 32'd1;
    assign w_stored_full = {w_b, r_stored};
    assign w_rs_ext      = 64'(r_record_start);

    always_comb begin
        w_vlen_full = r_vlen;
        w_vlen_full[{r_fbc[1:0], 3'b000} +: 8] = w_b;
    end

    // Record check at the last stored CRC byte: CRC, then order, then exhaustion.
    always_comb begin
        if (~r_crc != w_stored_full) begin
            w_st = ST_CRC_ERR;
        end else if (r_have_prev && (r_seq <= r_prev)) begin
            w_st = ST_SEQ_ORDER;
        end else if (r_seq == {SEQ_W{1'b1}}) begin
            w_st = ST_SEQ_EXHAUST;
        end else begin
            w_st = ST_OK;
        end
    end

    // Next phase and field byte count.
    always_comb begin
        n_phase = r_phase;
        n_fbc   = r_fbc;
        if (w_adv && i_in_item.eol) begin
            n_phase = PH_SEQ;
            n_fbc   = 3'd0;
        end else if (w_active) begin
            case (r_phase)
                PH_SEQ: begin
                    if (r_fbc == 3'd7) begin
                        n_phase = PH_OP;
                        n_fbc   = 3'd0;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                PH_OP: begin
                    if (w_is_put || w_is_del) begin
                        n_phase = PH_KLEN;
                        n_fbc   = 3'd0;
                    end
                end
                PH_KLEN: begin
                    if (r_fbc == 3'd3) begin
                        n_phase = PH_VLEN;
                        n_fbc   = 3'd0;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                PH_VLEN: begin
                    if (r_fbc == 3'd3) begin
                        if (r_klen != 32'd0) begin
                            n_phase = PH_KEY;
                        end else if (w_vlen_full != 32'd0) begin
                            n_phase = PH_VAL;
                        end else begin
                            n_phase = PH_CRC;
                        end
                        n_fbc = 3'd0;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                PH_KEY: begin
                    if (w_left_dec == 32'd0) begin
                        n_phase = (r_vlen != 32'd0) ? PH_VAL : PH_CRC;
                        n_fbc   = 3'd0;
                    end
                end
                PH_VAL: begin
                    if (w_left_dec == 32'd0) begin
                        n_phase = PH_CRC;
                        n_fbc   = 3'd0;
                    end
                end
                PH_CRC: begin
                    if (r_fbc == 3'd3) begin
                        n_phase = PH_SEQ;
                        n_fbc   = 3'd0;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                default: begin
                    n_phase = PH_SEQ;
                    n_fbc   = 3'd0;
                end
            endcase
        end
    end

    // Datapath registers and the result item.
    always_comb begin
        n_seq          = r_seq;
        n_op           = r_op;
        n_klen         = r_klen;
        n_vlen         = r_vlen;
        n_left         = r_left;
        n_crc          = r_crc;
        n_stored       = r_stored;
        n_prev         = r_prev;
        n_have_prev    = r_have_prev;
        n_byte_offset  = r_byte_offset;
        n_record_start = r_record_start;
        n_err          = r_err;
        w_emit         = 1'b0;
        w_res          = '0;

        if (w_adv && i_in_item.eol) begin
            // Stream end: report and return every field to its reset value.
            w_emit          = 1'b1;
            w_res.kind      = KIND_STREAM_END;
            w_res.status    = r_err;
            if ((r_err == ST_OK) && !w_start) begin
                w_res.status          = ST_TAIL;
                w_res.truncate_offset = w_rs_ext[TOFF_W-1:0];
            end
            w_res.next_sequence = r_have_prev ? (r_prev + 64'd1) : 64'd0;
            w_res.any_records   = r_have_prev;
            n_seq          = '0;
            n_op           = 1'b0;
            n_klen         = '0;
            n_vlen         = '0;
            n_left         = '0;
            n_crc          = CRC_INIT;
            n_stored       = '0;
            n_prev         = '0;
            n_have_prev    = 1'b0;
            n_byte_offset  = '0;
            n_record_start = '0;
            n_err          = ST_OK;
        end else if (w_active) begin
            if (w_start) begin
                n_record_start = r_byte_offset;
            end
            n_byte_offset = r_byte_offset + OFFSET_BITS'(1);
            case (r_phase)
                PH_SEQ: begin
                    n_crc = w_crc_next;
                    n_seq = w_seq_base;
                    n_seq[{r_fbc, 3'b000} +: 8] = w_b;
                end
                PH_OP: begin
                    n_crc = w_crc_next;
                    if (w_is_put) begin
                        n_op = 1'b0;
                    end else if (w_is_del) begin
                        n_op = 1'b1;
                    end else begin
                        n_err              = ST_BAD_OPCODE;
                        w_emit             = 1'b1;
                        w_res.kind         = KIND_RECORD_END;
                        w_res.sequence_res = r_seq;
                        w_res.status       = ST_BAD_OPCODE;
                    end
                end
                PH_KLEN: begin
                    n_crc = w_crc_next;
                    n_klen[{r_fbc[1:0], 3'b000} +: 8] = w_b;
                end
                PH_VLEN: begin
                    n_crc  = w_crc_next;
                    n_vlen = w_vlen_full;
                    if (r_fbc == 3'd3) begin
                        n_left = (r_klen != 32'd0) ? r_klen : w_vlen_full;
                    end
                end
                PH_KEY: begin
                    n_crc  = w_crc_next;
                    n_left = ((w_left_dec == 32'd0) && (r_vlen != 32'd0)) ? r_vlen
                                                                          : w_left_dec;
                    w_emit             = 1'b1;
                    w_res.kind         = KIND_KEY;
                    w_res.payload_byte = w_b;
                end
                PH_VAL: begin
                    n_crc              = w_crc_next;
                    n_left             = w_left_dec;
                    w_emit             = 1'b1;
                    w_res.kind         = KIND_VALUE;
                    w_res.payload_byte = w_b;
                end
                PH_CRC: begin
                    if (r_fbc != 3'd3) begin
                        n_stored[{r_fbc[1:0], 3'b000} +: 8] = w_b;
                    end else begin
                        if (w_st != ST_OK) begin
                            n_err = w_st;
                        end else begin
                            n_prev      = r_seq;
                            n_have_prev = 1'b1;
                        end
                        w_emit             = 1'b1;
                        w_res.kind         = KIND_RECORD_END;
                        w_res.sequence_res = r_seq;
                        w_res.record_op    = r_op;
                        w_res.status       = w_st;
                    end
                end
                default: begin
                    n_err = r_err;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_put_code <= 8'd0;
            r_del_code <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PUT_CODE:    r_put_code <= i_cfg_data;
                CFG_DELETE_CODE: r_del_code <= i_cfg_data;
                default:         r_put_code <= r_put_code;
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SEQ;
            r_fbc          <= 3'd0;
            r_seq          <= '0;
            r_op           <= 1'b0;
            r_klen         <= '0;
            r_vlen         <= '0;
            r_left         <= '0;
            r_crc          <= CRC_INIT;
            r_stored       <= '0;
            r_prev         <= '0;
            r_have_prev    <= 1'b0;
            r_byte_offset  <= '0;
            r_record_start <= '0;
            r_err          <= ST_OK;
        end else begin
            r_phase        <= n_phase;
            r_fbc          <= n_fbc;
            r_seq          <= n_seq;
            r_op           <= n_op;
            r_klen         <= n_klen;
            r_vlen         <= n_vlen;
            r_left         <= n_left;
            r_crc          <= n_crc;
            r_stored       <= n_stored;
            r_prev         <= n_prev;
            r_have_prev    <= n_have_prev;
            r_byte_offset  <= n_byte_offset;
            r_record_start <= n_record_start;
            r_err          <= n_err;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

`ifndef SYNTHESIS
    // A latched error silences every data byte.
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !i_in_item.eol && (r_err != ST_OK)) |-> !w_emit)
        else $error("result produced while an error is latched");

    // Only the sequence field counts past three bytes.
    a_fbc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEQ) |-> (r_fbc <= 3'd3))
        else $error("field byte count out of range");

    // A stream end returns the parser to a fresh log.
    a_eol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && i_in_item.eol) |=>
            ((r_err == ST_OK) && (r_phase == PH_SEQ) && !r_have_prev))
        else $error("state not cleared after stream end");

    // A stalled result is never overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_adv)
        else $error("result register overrun");
`endif

endmodule

[tb/tb_log_record_deframer_crc32.sv]
// Self-checking testbench for log_record_deframer_crc32: a directed table
// followed by random logs, checked against an in-bench record parser model.
// Depends on lrd_pkg and the log_record_deframer_crc32 RTL.
module tb_log_record_deframer_crc32;
    timeunit 1ns;
    timeprecision 1ps;

    import lrd_pkg::*;

    localparam int ITEM_TARGET   = 1650;
    localparam int CUT_FULL      = 1 << 30;
    localparam int SETTLE_CYCLES = 8;
    localparam t_result NO_RES   = '0;

    typedef enum logic [1:0] {
        ROW_BYTE   = 2'd0,
        ROW_EOL    = 2'd1,
        ROW_RECORD = 2'd2
    } t_row_kind;

    // One row of the directed stimulus table.
    typedef struct {
        t_row_kind   what;
        logic [7:0]  data;
        logic [63:0] seq;
        logic [7:0]  opb;
        logic [31:0] klen;
        logic [31:0] vlen;
        bit          crc_bad;
        bit          typed;
        t_result     want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [7:0]   i_cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tuser;   // [0] end_of_log
    logic         m_tvalid;
    logic         m_tready;
    // [7:0] payload_byte, [71:8] sequence_res, [72] record_op, [75:73] status,
    // [123:76] truncate_offset, [187:124] next_sequence, [188] any_records
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;   // [1:0] kind

    // Parser model state and its copy of the opcode registers.
    logic [7:0]   put_byte;
    logic [7:0]   del_byte;
    t_phase       parse_phase;
    int           fld_cnt;
    logic [63:0]  seq_acc;
    logic         op_is_delete;
    logic [31:0]  klen_acc;
    logic [31:0]  vlen_acc;
    logic [31:0]  bytes_left;
    logic [31:0]  crc_acc;
    logic [31:0]  crc_field;
    logic [63:0]  last_good_seq;
    logic         have_good;
    logic [47:0]  off_ctr;
    logic [47:0]  rec_begin;
    t_status      err_code;

    t_result      pending_results[$];
    t_row         dir_rows[$];

    int           err_count;
    int           n_transfers;
    int           n_payload;
    int           n_rec_end;
    int           n_stream_end;
    int           n_configs;
    bit           tx_calm;
    bit           rx_calm;

    log_record_deframer_crc32 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Reflected CRC-32, one bit per iteration.
    function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic t_result mk_result(input t_kind k, input logic [63:0] seq,
                                          input t_status st, input logic [47:0] toff,
                                          input logic [63:0] nxt, input logic any);
        t_result r;
        r = '0;
        r.kind            = k;
        r.sequence_res    = seq;
        r.status          = st;
        r.truncate_offset = toff;
        r.next_sequence   = nxt;
        r.any_records     = any;
        return r;
    endfunction

    function automatic t_row mk_row(input t_row_kind what, input logic [7:0] data,
                                    input logic [63:0] seq, input logic [7:0] opb,
                                    input logic [31:0] klen, input logic [31:0] vlen,
                                    input bit crc_bad, input bit typed, input t_result want);
        t_row r;
        r.what    = what;
        r.data    = data;
        r.seq     = seq;
        r.opb     = opb;
        r.klen    = klen;
        r.vlen    = vlen;
        r.crc_bad = crc_bad;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    // Queue one predicted result for the result side.
    task automatic expect_result(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Append one row to the directed table.
    task automatic add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Return the parser model to its post-reset state; registers are kept.
    task automatic clear_parse();
        parse_phase   = PH_SEQ;
        fld_cnt       = 0;
        seq_acc       = '0;
        op_is_delete  = 1'b0;
        klen_acc      = '0;
        vlen_acc      = '0;
        bytes_left    = '0;
        crc_acc       = CRC_INIT;
        crc_field     = '0;
        last_good_seq = '0;
        have_good     = 1'b0;
        off_ctr       = '0;
        rec_begin     = '0;
        err_code      = ST_OK;
    endtask

    // Model of one input transfer: advances the parser and yields its result, if any.
    task automatic deframe_byte(input logic eol, input logic [7:0] b,
                                output bit produced, output t_result res);
        int      sh;
        t_status st;
        produced = 1'b0;
        res      = '0;
        if (eol) begin
            // End of log: latched error, unfinished record, or clean stop.
            res.kind   = KIND_STREAM_END;
            res.status = err_code;
            if (err_code == ST_OK && !(parse_phase == PH_SEQ && fld_cnt == 0)) begin
                res.status          = ST_TAIL;
                res.truncate_offset = rec_begin;
            end
            res.next_sequence = have_good ? last_good_seq + 64'd1 : 64'd0;
            res.any_records   = have_good;
            produced = 1'b1;
            clear_parse();
        end else if (err_code == ST_OK) begin
            if (parse_phase == PH_SEQ && fld_cnt == 0) begin
                rec_begin = off_ctr;
                crc_acc   = CRC_INIT;
                seq_acc   = '0;
            end
            off_ctr = off_ctr + 48'd1;
            sh = (fld_cnt % 8) * 8;
            case (parse_phase)
                PH_SEQ: begin
                    crc_acc = crc32_step(crc_acc, b);
                    seq_acc = seq_acc | ({56'd0, b} << sh);
                    fld_cnt++;
                    if (fld_cnt >= 8) begin
                        parse_phase = PH_OP;
                        fld_cnt = 0;
                    end
                end
                PH_OP: begin
                    crc_acc = crc32_step(crc_acc, b);
                    if (b == put_byte) begin
                        op_is_delete = 1'b0;
                    end else if (b == del_byte) begin
                        op_is_delete = 1'b1;
                    end else begin
                        // An unknown opcode ends the record at once and latches.
                        err_code = ST_BAD_OPCODE;
                        res = mk_result(KIND_RECORD_END, seq_acc, ST_BAD_OPCODE, '0, '0, 1'b0);
                        produced = 1'b1;
                    end
                    if (err_code == ST_OK) begin
                        parse_phase = PH_KLEN;
                        fld_cnt = 0;
                        klen_acc = '0;
                    end
                end
                PH_KLEN: begin
                    crc_acc = crc32_step(crc_acc, b);
                    klen_acc = klen_acc | ({24'd0, b} << sh);
                    fld_cnt++;
                    if (fld_cnt >= 4) begin
                        parse_phase = PH_VLEN;
                        fld_cnt = 0;
                        vlen_acc = '0;
                    end
                end
                PH_VLEN: begin
                    crc_acc = crc32_step(crc_acc, b);
                    vlen_acc = vlen_acc | ({24'd0, b} << sh);
                    fld_cnt++;
                    if (fld_cnt >= 4) begin
                        // Empty key or value fields are skipped.
                        if (klen_acc != 0) begin
                            parse_phase = PH_KEY;
                            bytes_left = klen_acc;
                        end else if (vlen_acc != 0) begin
                            parse_phase = PH_VAL;
                            bytes_left = vlen_acc;
                        end else begin
                            parse_phase = PH_CRC;
                        end
                        fld_cnt = 0;
                    end
                end
                PH_KEY: begin
                    crc_acc = crc32_step(crc_acc, b);
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0) begin
                        if (vlen_acc != 0) begin
                            parse_phase = PH_VAL;
                            bytes_left = vlen_acc;
                        end else begin
                            parse_phase = PH_CRC;
                        end
                        fld_cnt = 0;
                    end
                    res.kind = KIND_KEY;
                    res.payload_byte = b;
                    produced = 1'b1;
                end
                PH_VAL: begin
                    crc_acc = crc32_step(crc_acc, b);
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0) begin
                        parse_phase = PH_CRC;
                        fld_cnt = 0;
                    end
                    res.kind = KIND_VALUE;
                    res.payload_byte = b;
                    produced = 1'b1;
                end
                default: begin
                    if (fld_cnt == 0) crc_field = '0;
                    crc_field = crc_field | ({24'd0, b} << sh);
                    fld_cnt++;
                    if (fld_cnt >= 4) begin
                        // CRC first, then ordering, then the all-ones sequence.
                        st = ST_OK;
                        if (~crc_acc != crc_field) st = ST_CRC_ERR;
                        else if (have_good && seq_acc <= last_good_seq) st = ST_SEQ_ORDER;
                        else if (seq_acc == '1) st = ST_SEQ_EXHAUST;
                        if (st != ST_OK) begin
                            err_code = st;
                        end else begin
                            last_good_seq = seq_acc;
                            have_good = 1'b1;
                        end
                        res = mk_result(KIND_RECORD_END, seq_acc, st, '0, '0, 1'b0);
                        res.record_op = op_is_delete;
                        produced = 1'b1;
                        parse_phase = PH_SEQ;
                        fld_cnt = 0;
                    end
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, wanted %0h (result %0d)", what, got, want,
                 n_rec_end + n_stream_end + n_payload);
        err_count++;
    endtask

    // Drive one input transfer, then predict its result once accepted.
    task automatic send_item(input logic eol, input logic [7:0] data,
                             input bit typed = 1'b0, input t_result want = NO_RES);
        int      gap;
        bit      produced;
        t_result res;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= eol;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n_transfers++;
        deframe_byte(eol, data, produced, res);
        if (typed) expect_result(want);
        else if (produced) expect_result(res);
    endtask

    task automatic tx_idle();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, plus a settling margin.
    task automatic wait_drained();
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] put_v, input logic [7:0] del_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PUT_CODE;
        i_cfg_data <= put_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DELETE_CODE;
        i_cfg_data <= del_v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        put_byte = put_v;
        del_byte = del_v;
        n_configs++;
    endtask

    // Send one record with a computed CRC; cut stops after that many bytes.
    task automatic send_record(input logic [63:0] seq, input logic [7:0] opb,
                               input logic [31:0] klen, input logic [31:0] vlen,
                               input bit crc_bad, input int cut);
        logic [7:0]      rec_bytes[$];
        logic [31:0]     crc;
        longint unsigned body;
        body = longint'(klen) + longint'(vlen);
        for (int i = 0; i < 8; i++) rec_bytes.insert(rec_bytes.size(), seq[8*i +: 8]);
        rec_bytes.insert(rec_bytes.size(), opb);
        for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), vlen[8*i +: 8]);
        for (longint unsigned j = 0; j < body && rec_bytes.size() < cut; j++)
            rec_bytes.insert(rec_bytes.size(), 8'($urandom));
        crc = CRC_INIT;
        foreach (rec_bytes[k]) crc = crc32_step(crc, rec_bytes[k]);
        crc = ~crc;
        if (crc_bad) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), crc[8*i +: 8]);
        for (int k = 0; k < rec_bytes.size() && k < cut; k++) send_item(1'b0, rec_bytes[k]);
    endtask

    // One random log: mostly valid records, with errors, tails and noise mixed in.
    task automatic send_random_log();
        logic [63:0] seq;
        logic [63:0] prev_sent;
        logic [31:0] klen;
        logic [31:0] vlen;
        logic [7:0]  opb;
        bit          have_sent;
        bit          stop;
        int          r;
        int          n_rec;
        r = $urandom_range(0, 9);
        if (r < 6) seq = 64'($urandom_range(0, 1000));
        else if (r < 8) seq = {$urandom, $urandom};
        else seq = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4));
        n_rec = $urandom_range(0, 8);
        have_sent = 1'b0;
        prev_sent = '0;
        stop = 1'b0;
        for (int i = 0; i < n_rec && !stop; i++) begin
            opb  = $urandom_range(0, 1) ? put_byte : del_byte;
            klen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
            vlen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
            r = $urandom_range(0, 99);
            if (r < 76 || (r < 87 && r >= 82 && !have_sent)) begin
                send_record(seq, opb, klen, vlen, 1'b0, CUT_FULL);
                prev_sent = seq;
                have_sent = 1'b1;
                seq = seq + 64'($urandom_range(1, 3));
            end else if (r < 82) begin
                send_record(seq, opb, klen, vlen, 1'b1, CUT_FULL);
            end else if (r < 87) begin
                send_record(prev_sent - 64'($urandom_range(0, 2)), opb, klen, vlen, 1'b0,
                            CUT_FULL);
            end else if (r < 91) begin
                do opb = 8'($urandom); while (opb == put_byte || opb == del_byte);
                send_record(seq, opb, klen, vlen, 1'b0, 9 + $urandom_range(0, 3));
            end else if (r < 96) begin
                // Unfinished record, sometimes with a huge length field.
                if ($urandom_range(0, 1)) klen = $urandom;
                if ($urandom_range(0, 1)) vlen = $urandom;
                send_record(seq, opb, klen, vlen, 1'b0, $urandom_range(1, 26));
                stop = 1'b1;
            end else begin
                repeat ($urandom_range(1, 40)) send_item(1'b0, 8'($urandom));
                stop = 1'b1;
            end
            if (err_code != ST_OK) stop = 1'b1;
        end
        // A latched error must swallow any further bytes.
        if (err_code != ST_OK)
            repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom));
        send_item(1'b1, 8'($urandom));
    endtask

    // Result side: random stalls, then compare each transfer with the oldest prediction.
    initial begin : result_sink
        int      stall;
        t_result got;
        t_result want;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            got = t_result'({m_tdata[188:0], m_tuser});
            case (got.kind)
                KIND_RECORD_END: n_rec_end++;
                KIND_STREAM_END: n_stream_end++;
                default:         n_payload++;
            endcase
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", 64'(got.kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", 64'(got.payload_byte),
                                    64'(want.payload_byte));
                if (got.sequence_res !== want.sequence_res)
                    report_mismatch("sequence_res", got.sequence_res, want.sequence_res);
                if (got.record_op !== want.record_op)
                    report_mismatch("record_op", 64'(got.record_op), 64'(want.record_op));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.truncate_offset !== want.truncate_offset)
                    report_mismatch("truncate_offset", 64'(got.truncate_offset),
                                    64'(want.truncate_offset));
                if (got.next_sequence !== want.next_sequence)
                    report_mismatch("next_sequence", got.next_sequence, want.next_sequence);
                if (got.any_records !== want.any_records)
                    report_mismatch("any_records", 64'(got.any_records),
                                    64'(want.any_records));
            end
        end
    end

    // Stimulus: reset, directed table, then random logs under changing opcode settings.
    initial begin : stimulus
        logic [7:0] v;
        int         phase_no;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_PUT_CODE;
        i_cfg_data <= 8'd0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'd0;
        s_tuser    <= 1'b0;
        err_count = 0;
        n_transfers = 0;
        n_payload = 0;
        n_rec_end = 0;
        n_stream_end = 0;
        n_configs = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        put_byte = 8'd0;
        del_byte = 8'd1;
        clear_parse();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run with the reset opcodes (put 0, delete 1).
        // Clean stop right after reset.
        add_row(mk_row(ROW_EOL, 8'h00, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_OK, '0, '0, 1'b0)));
        // Unknown opcode after an extreme sequence, then a byte the latch swallows.
        for (int i = 0; i < 8; i++)
            add_row(mk_row(ROW_BYTE, 8'h88 + 8'(i * 17), '0, '0, '0, '0, 1'b0,
                           1'b0, NO_RES));
        add_row(mk_row(ROW_BYTE, 8'hFF, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_RECORD_END, 64'hFFEE_DDCC_BBAA_9988,
                                 ST_BAD_OPCODE, '0, '0, 1'b0)));
        add_row(mk_row(ROW_BYTE, 8'h5A, '0, '0, '0, '0, 1'b0, 1'b0, NO_RES));
        add_row(mk_row(ROW_EOL, 8'hFF, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_BAD_OPCODE, '0, '0,
                                 1'b0)));
        // Empty payload, put and delete, then a repeated sequence.
        add_row(mk_row(ROW_RECORD, '0, 64'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_RECORD, '0, 64'd5, 8'd1, 32'd3, 32'd2, 1'b0, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_RECORD, '0, 64'd6, 8'd1, 32'd1, 32'd0, 1'b0, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_RECORD, '0, 64'd6, 8'd0, 32'd0, 32'd1, 1'b0, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_EOL, 8'h00, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_SEQ_ORDER, '0, 64'd7,
                                 1'b1)));
        // CRC mismatch on the first record.
        add_row(mk_row(ROW_RECORD, '0, 64'd1, 8'd0, 32'd2, 32'd0, 1'b1, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_EOL, 8'h00, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_CRC_ERR, '0, '0, 1'b0)));
        // All-ones sequence is exhausted.
        add_row(mk_row(ROW_RECORD, '0, '1, 8'd1, 32'd0, 32'd2, 1'b0, 1'b0,
                       NO_RES));
        add_row(mk_row(ROW_EOL, 8'h00, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_SEQ_EXHAUST, '0, '0,
                                 1'b0)));
        // Largest usable sequence, then a tail that starts right after it.
        add_row(mk_row(ROW_RECORD, '0, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 32'd0,
                       32'd0, 1'b0, 1'b0, NO_RES));
        add_row(mk_row(ROW_BYTE, 8'h00, '0, '0, '0, '0, 1'b0, 1'b0, NO_RES));
        add_row(mk_row(ROW_BYTE, 8'hFF, '0, '0, '0, '0, 1'b0, 1'b0, NO_RES));
        add_row(mk_row(ROW_BYTE, 8'h00, '0, '0, '0, '0, 1'b0, 1'b0, NO_RES));
        add_row(mk_row(ROW_EOL, 8'h00, '0, '0, '0, '0, 1'b0, 1'b1,
                       mk_result(KIND_STREAM_END, '0, ST_TAIL, 48'd21, '1, 1'b1)));

        foreach (dir_rows[i]) begin
            case (dir_rows[i].what)
                ROW_RECORD: send_record(dir_rows[i].seq, dir_rows[i].opb, dir_rows[i].klen,
                                        dir_rows[i].vlen, dir_rows[i].crc_bad, CUT_FULL);
                default:    send_item(dir_rows[i].what == ROW_EOL, dir_rows[i].data,
                                      dir_rows[i].typed, dir_rows[i].want);
            endcase
        end

        // Random phases; each starts idle with a fresh opcode setting.
        phase_no = 0;
        while (n_transfers < ITEM_TARGET) begin
            tx_idle();
            wait_drained();
            case (phase_no % 5)
                0: write_config(8'h00, 8'hFF);
                1: write_config(8'hFF, 8'h00);
                2: begin
                    // Equal codes: the byte means put.
                    v = 8'($urandom);
                    write_config(v, v);
                end
                3: write_config(8'hFF, 8'hFF);
                default: write_config(8'($urandom), 8'($urandom));
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) send_random_log();
            phase_no++;
        end

        tx_idle();
        wait_drained();
        $display("Run covered %0d input transfers over %0d opcode settings.",
                 n_transfers, n_configs);
        $display("Checked %0d payload bytes, %0d record reports and %0d log-end reports.",
                 n_payload, n_rec_end, n_stream_end);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
